@@ design/i2p_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, codes and the precedence table of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    KIND_DIGIT  = 3'd0,
    KIND_NUMEND = 3'd1,
    KIND_VAR    = 3'd2,
    KIND_OP     = 3'd3,
    KIND_WARN   = 3'd4
  } kind_t;

  localparam logic [3:0] OP_AND      = 4'd0;
  localparam logic [3:0] OP_XOR      = 4'd1;
  localparam logic [3:0] OP_OR       = 4'd2;
  localparam logic [3:0] OP_EQ       = 4'd3;
  localparam logic [3:0] OP_GE       = 4'd4;
  localparam logic [3:0] OP_LE       = 4'd5;
  localparam logic [3:0] OP_SHL      = 4'd6;
  localparam logic [3:0] OP_SHR      = 4'd7;
  localparam logic [3:0] OP_ADD      = 4'd8;
  localparam logic [3:0] OP_SUB      = 4'd9;
  localparam logic [3:0] OP_MUL      = 4'd10;
  localparam logic [3:0] OP_DIV      = 4'd11;
  localparam logic [3:0] OP_MOD      = 4'd12;
  localparam logic [3:0] CODE_LPAREN = 4'd13;

  localparam logic [2:0] WARN_AFTER_LT = 3'd0;
  localparam logic [2:0] WARN_AFTER_GT = 3'd1;
  localparam logic [2:0] WARN_AFTER_EQ = 3'd2;
  localparam logic [2:0] WARN_UNKNOWN  = 3'd3;
  localparam logic [2:0] WARN_FULL     = 3'd4;

  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_LT   = 2'd1;
  localparam logic [1:0] PFX_GT   = 2'd2;
  localparam logic [1:0] PFX_EQ   = 2'd3;

  localparam logic [6:0] LVL_BIT   = 7'd10;
  localparam logic [6:0] LVL_EQ    = 7'd11;
  localparam logic [6:0] LVL_REL   = 7'd12;
  localparam logic [6:0] LVL_SHIFT = 7'd13;
  localparam logic [6:0] LVL_ADD   = 7'd14;
  localparam logic [6:0] LVL_MUL   = 7'd15;
  localparam logic [6:0] LVL_PAREN = 7'd99;

  function automatic logic [6:0] level_of(input logic [3:0] code);
    logic [6:0] lvl;
    case (code)
      OP_AND, OP_XOR, OP_OR:  lvl = LVL_BIT;
      OP_EQ:                  lvl = LVL_EQ;
      OP_GE, OP_LE:           lvl = LVL_REL;
      OP_SHL, OP_SHR:         lvl = LVL_SHIFT;
      OP_ADD, OP_SUB:         lvl = LVL_ADD;
      OP_MUL, OP_DIV, OP_MOD: lvl = LVL_MUL;
      default:                lvl = LVL_PAREN;
    endcase
    return lvl;
  endfunction

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DIGIT,
    ACT_VAR,
    ACT_WARN,
    ACT_OPER,
    ACT_LPAREN,
    ACT_RPAREN,
    ACT_FLUSH
  } act_t;

  typedef enum logic [2:0] {
    SRC_NUMEND,
    SRC_LEAD_WARN,
    SRC_ITEM,
    SRC_TOP,
    SRC_FULL
  } emit_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_ACT,
    ST_TOP,
    ST_WAIT,
    ST_PUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic [3:0] op;
    logic [2:0] warn;
  } tok_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_src_t src;
    logic      pop;
    logic      push;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    act_t act;
    logic lead_numend;
    logic lead_warn;
    logic emit_ok;
    logic out_free;
    logic hold_valid;
    logic count_zero;
    logic stack_full;
    logic top_lparen;
    logic top_stop;
  } dp_stat_t;

endpackage

@@ design/i2p_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_in_if
// Expression byte channel: valid/ready with one text byte or an end mark.
// ----------------------------------------------------------------------------
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ design/i2p_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_out_if
// Postfix token channel: valid/ready with one token per transfer.
// ----------------------------------------------------------------------------
interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [3:0] digit_value;
  logic [3:0] operator_code;
  logic [2:0] warning_code;
  logic       last_of_run;

  modport source (
    output valid, output token_kind, output digit_value, output operator_code,
    output warning_code, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input digit_value, input operator_code,
    input warning_code, input last_of_run, output ready
  );
endinterface

@@ design/i2p_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/i2p_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: steps one accepted byte through lead tokens, its action,
// the operator stack walk and the final token release.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2p_pkg::dp_stat_t  st,
  output i2p_pkg::dp_cmd_t   cmd
);

  i2p_pkg::state_t state;
  i2p_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2p_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.src    = i2p_pkg::SRC_ITEM;
    case (state)
      i2p_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = i2p_pkg::ST_LEAD;
        end
      end
      i2p_pkg::ST_LEAD: begin
        if (st.lead_numend) begin
          if (st.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.src  = i2p_pkg::SRC_NUMEND;
          end
        end else if (st.lead_warn) begin
          if (st.emit_ok) begin
            cmd.emit = 1'b1;
            cmd.src  = i2p_pkg::SRC_LEAD_WARN;
          end
        end else begin
          state_next = i2p_pkg::ST_ACT;
        end
      end
      i2p_pkg::ST_ACT, i2p_pkg::ST_WAIT: begin
        case (st.act)
          i2p_pkg::ACT_DIGIT, i2p_pkg::ACT_VAR, i2p_pkg::ACT_WARN: begin
            if (st.emit_ok) begin
              cmd.emit   = 1'b1;
              cmd.src    = i2p_pkg::SRC_ITEM;
              state_next = i2p_pkg::ST_DONE;
            end
          end
          i2p_pkg::ACT_OPER: begin
            state_next = st.count_zero ? i2p_pkg::ST_PUSH : i2p_pkg::ST_TOP;
          end
          i2p_pkg::ACT_RPAREN, i2p_pkg::ACT_FLUSH: begin
            state_next = st.count_zero ? i2p_pkg::ST_DONE : i2p_pkg::ST_TOP;
          end
          i2p_pkg::ACT_LPAREN: begin
            state_next = i2p_pkg::ST_PUSH;
          end
          default: begin
            state_next = i2p_pkg::ST_DONE;
          end
        endcase
      end
      i2p_pkg::ST_TOP: begin
        case (st.act)
          i2p_pkg::ACT_OPER: begin
            if (st.top_stop) begin
              state_next = i2p_pkg::ST_PUSH;
            end else if (st.emit_ok) begin
              cmd.emit   = 1'b1;
              cmd.src    = i2p_pkg::SRC_TOP;
              cmd.pop    = 1'b1;
              state_next = i2p_pkg::ST_WAIT;
            end
          end
          i2p_pkg::ACT_RPAREN: begin
            if (st.top_lparen) begin
              cmd.pop    = 1'b1;
              state_next = i2p_pkg::ST_DONE;
            end else if (st.emit_ok) begin
              cmd.emit   = 1'b1;
              cmd.src    = i2p_pkg::SRC_TOP;
              cmd.pop    = 1'b1;
              state_next = i2p_pkg::ST_WAIT;
            end
          end
          i2p_pkg::ACT_FLUSH: begin
            // unmatched '(' is dropped silently
            if (st.top_lparen) begin
              cmd.pop    = 1'b1;
              state_next = i2p_pkg::ST_WAIT;
            end else if (st.emit_ok) begin
              cmd.emit   = 1'b1;
              cmd.src    = i2p_pkg::SRC_TOP;
              cmd.pop    = 1'b1;
              state_next = i2p_pkg::ST_WAIT;
            end
          end
          default: begin
            state_next = i2p_pkg::ST_DONE;
          end
        endcase
      end
      i2p_pkg::ST_PUSH: begin
        if (st.stack_full) begin
          if (st.emit_ok) begin
            cmd.emit   = 1'b1;
            cmd.src    = i2p_pkg::SRC_FULL;
            state_next = i2p_pkg::ST_DONE;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = i2p_pkg::ST_DONE;
        end
      end
      i2p_pkg::ST_DONE: begin
        if (st.hold_valid) begin
          if (st.out_free) begin
            cmd.finish = 1'b1;
            state_next = i2p_pkg::ST_IDLE;
          end
        end else begin
          state_next = i2p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = i2p_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/i2p_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_dpath
// Datapath: byte decode, number and prefix state, operator stack in RAM,
// one-token hold stage (marks the last token) and output register.
// ----------------------------------------------------------------------------
module i2p_dpath #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  input  i2p_pkg::dp_cmd_t  cmd,
  output i2p_pkg::dp_stat_t st,
  i2p_out_if.source         tokens
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_AMP   = "&";
  localparam logic [7:0] CH_CARET = "^";
  localparam logic [7:0] CH_BAR   = "|";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_LP    = "(";
  localparam logic [7:0] CH_RP    = ")";
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // per-byte state
  logic [1:0]    pfx;
  logic          num_open;
  i2p_pkg::act_t act;
  logic [3:0]    code;
  logic [3:0]    digit;
  logic [2:0]    act_warn;
  logic          lead_numend;
  logic          lead_warn;
  logic [2:0]    lead_wcode;

  // decode
  i2p_pkg::act_t d_act;
  logic [3:0]    d_code;
  logic [3:0]    d_digit;
  logic [2:0]    d_warn;
  logic          d_lead_numend;
  logic          d_lead_warn;
  logic [1:0]    d_pfx_next;
  logic          d_num_open_next;
  logic [2:0]    pfx_wcode;
  logic [3:0]    digit_off;

  assign pfx_wcode = {1'b0, pfx - 2'd1};
  assign digit_off = 4'(in_byte - CH_0);

  always_comb begin
    d_act           = i2p_pkg::ACT_NONE;
    d_code          = 4'd0;
    d_digit         = 4'd0;
    d_warn          = 3'd0;
    d_lead_numend   = 1'b0;
    d_lead_warn     = 1'b0;
    d_pfx_next      = i2p_pkg::PFX_NONE;
    d_num_open_next = num_open;
    if (end_of_input) begin
      d_act           = i2p_pkg::ACT_FLUSH;
      d_lead_numend   = num_open;
      d_lead_warn     = (pfx != i2p_pkg::PFX_NONE);
      d_num_open_next = 1'b0;
    end else if (pfx != i2p_pkg::PFX_NONE) begin
      d_act  = i2p_pkg::ACT_WARN;
      d_warn = pfx_wcode;
      case (pfx)
        i2p_pkg::PFX_LT: begin
          if (in_byte == CH_LT) begin
            d_act  = i2p_pkg::ACT_OPER;
            d_code = i2p_pkg::OP_SHL;
          end else if (in_byte == CH_EQ) begin
            d_act  = i2p_pkg::ACT_OPER;
            d_code = i2p_pkg::OP_LE;
          end
        end
        i2p_pkg::PFX_GT: begin
          if (in_byte == CH_GT) begin
            d_act  = i2p_pkg::ACT_OPER;
            d_code = i2p_pkg::OP_SHR;
          end else if (in_byte == CH_EQ) begin
            d_act  = i2p_pkg::ACT_OPER;
            d_code = i2p_pkg::OP_GE;
          end
        end
        default: begin
          if (in_byte == CH_EQ) begin
            d_act  = i2p_pkg::ACT_OPER;
            d_code = i2p_pkg::OP_EQ;
          end
        end
      endcase
    end else if (in_byte >= CH_0 && in_byte <= CH_9) begin
      d_act           = i2p_pkg::ACT_DIGIT;
      d_digit         = digit_off;
      d_num_open_next = 1'b1;
    end else begin
      d_lead_numend   = num_open;
      d_num_open_next = 1'b0;
      case (in_byte)
        CH_T:     d_act = i2p_pkg::ACT_VAR;
        CH_AMP:   begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_AND; end
        CH_CARET: begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_XOR; end
        CH_BAR:   begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_OR;  end
        CH_PLUS:  begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_ADD; end
        CH_MINUS: begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_SUB; end
        CH_STAR:  begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_MUL; end
        CH_SLASH: begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_DIV; end
        CH_PCT:   begin d_act = i2p_pkg::ACT_OPER; d_code = i2p_pkg::OP_MOD; end
        CH_LT:    d_pfx_next = i2p_pkg::PFX_LT;
        CH_GT:    d_pfx_next = i2p_pkg::PFX_GT;
        CH_EQ:    d_pfx_next = i2p_pkg::PFX_EQ;
        CH_LP:    begin d_act = i2p_pkg::ACT_LPAREN; d_code = i2p_pkg::CODE_LPAREN; end
        CH_RP:    d_act = i2p_pkg::ACT_RPAREN;
        CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR: d_act = i2p_pkg::ACT_NONE;
        default:  begin d_act = i2p_pkg::ACT_WARN; d_warn = i2p_pkg::WARN_UNKNOWN; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pfx         <= i2p_pkg::PFX_NONE;
      num_open    <= 1'b0;
      act         <= i2p_pkg::ACT_NONE;
      lead_numend <= 1'b0;
      lead_warn   <= 1'b0;
    end else if (cmd.accept) begin
      pfx         <= d_pfx_next;
      num_open    <= d_num_open_next;
      act         <= d_act;
      lead_numend <= d_lead_numend;
      lead_warn   <= d_lead_warn;
    end else if (cmd.emit) begin
      if (cmd.src == i2p_pkg::SRC_NUMEND) begin
        lead_numend <= 1'b0;
      end
      if (cmd.src == i2p_pkg::SRC_LEAD_WARN) begin
        lead_warn <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code       <= d_code;
      digit      <= d_digit;
      act_warn   <= d_warn;
      lead_wcode <= pfx_wcode;
    end
  end

  // operator stack
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [3:0]    top;
  logic          push_we;

  assign count_m1 = count - CW'(1);
  assign push_we  = cmd.push && (count != CW'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push_we) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      count <= count_m1;
    end
  end

  i2p_ram #(
    .WIDTH (4),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_we),
    .waddr (count[IW-1:0]),
    .wdata (code),
    .raddr (count_m1[IW-1:0]),
    .rdata (top)
  );

  // token build
  i2p_pkg::tok_t new_tok;

  always_comb begin
    new_tok      = '0;
    new_tok.kind = i2p_pkg::KIND_DIGIT;
    case (cmd.src)
      i2p_pkg::SRC_NUMEND: new_tok.kind = i2p_pkg::KIND_NUMEND;
      i2p_pkg::SRC_LEAD_WARN: begin
        new_tok.kind = i2p_pkg::KIND_WARN;
        new_tok.warn = lead_wcode;
      end
      i2p_pkg::SRC_TOP: begin
        new_tok.kind = i2p_pkg::KIND_OP;
        new_tok.op   = top;
      end
      i2p_pkg::SRC_FULL: begin
        new_tok.kind = i2p_pkg::KIND_WARN;
        new_tok.warn = i2p_pkg::WARN_FULL;
      end
      default: begin
        case (act)
          i2p_pkg::ACT_DIGIT: new_tok.digit = digit;
          i2p_pkg::ACT_VAR:   new_tok.kind  = i2p_pkg::KIND_VAR;
          default: begin
            new_tok.kind = i2p_pkg::KIND_WARN;
            new_tok.warn = act_warn;
          end
        endcase
      end
    endcase
  end

  // hold stage + output register
  i2p_pkg::tok_t hold;
  logic          hold_valid;
  i2p_pkg::tok_t out_tok;
  logic          out_last;
  logic          out_valid;
  logic          out_free;
  logic          out_load;

  assign out_free = !out_valid || tokens.ready;
  assign out_load = (cmd.emit && hold_valid) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.finish) begin
        hold_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hold <= new_tok;
    end
    if (out_load) begin
      out_tok  <= hold;
      out_last <= cmd.finish;
    end
  end

  assign tokens.valid         = out_valid;
  assign tokens.token_kind    = out_tok.kind;
  assign tokens.digit_value   = out_tok.digit;
  assign tokens.operator_code = out_tok.op;
  assign tokens.warning_code  = out_tok.warn;
  assign tokens.last_of_run   = out_last;

  // status
  assign st.act         = act;
  assign st.lead_numend = lead_numend;
  assign st.lead_warn   = lead_warn;
  assign st.emit_ok     = !hold_valid || out_free;
  assign st.out_free    = out_free;
  assign st.hold_valid  = hold_valid;
  assign st.count_zero  = (count == '0);
  assign st.stack_full  = (count == CW'(STACK_DEPTH));
  assign st.top_lparen  = (top == i2p_pkg::CODE_LPAREN);
  assign st.top_stop    = (top >= i2p_pkg::CODE_LPAREN) ||
                          (i2p_pkg::level_of(top) < i2p_pkg::level_of(code));

endmodule

@@ design/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of infix expression text to postfix tokens.
// ----------------------------------------------------------------------------
// Usage:
//   expr   : one text byte per transfer, or an end mark (end_of_input = 1)
//            that closes any open number and flushes the operator stack.
//   tokens : postfix tokens, one per transfer; last_of_run marks the final
//            token caused by one input byte. A byte may cause no token.
// Sequence:
//   A byte is taken in the idle cycle and walked through a sequencer; with
//   no stack work it passes the lead, action and done states. Further steps
//   are leading number-end or prefix warning tokens, a push or full-stack
//   warning, the check of a stack top that stops an operator, the '('
//   removed by ')', and per entry popped an emit, then a fetch of the new
//   top (registered stack read). The next byte is taken only once the
//   current one is done.
// Reset: synchronous; stack empty, no number open, no prefix pending,
//   no token queued.
// Stall: a token is held one deep before the output register so the last
//   one can be marked; with both full and tokens.ready low, emits wait.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  i2p_in_if.sink     expr,
  i2p_out_if.source  tokens
);

  i2p_pkg::dp_cmd_t  cmd;
  i2p_pkg::dp_stat_t st;
  logic              in_ready;

  assign expr.ready = in_ready;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (expr.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (expr.in_byte),
    .end_of_input (expr.end_of_input),
    .cmd          (cmd),
    .st           (st),
    .tokens       (tokens)
  );

endmodule
